@@ rtl/core/wcsp_pkg.sv @@
// Package for the WAVE chunk stream parser: widths, tags, phase and status codes, result type.
package wcsp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned TOTAL_W  = 34;
  localparam int unsigned PHASE_W  = 3;

  // Chunk tags and RIFF form, little-endian as gathered
  localparam logic [WORD_W-1:0] TAG_RIFF  = 32'h4646_4952;
  localparam logic [WORD_W-1:0] TAG_FMT   = 32'h2074_6D66;
  localparam logic [WORD_W-1:0] TAG_DATA  = 32'h6174_6164;
  localparam logic [WORD_W-1:0] FORM_WAVE = 32'h4556_4157;

  localparam logic [HALF_W-1:0] FMT_PCM = 16'd1;

  // Parse phases
  localparam logic [PHASE_W-1:0] PH_HDR   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FORM  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_FMT   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_EXT   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SKIPX = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_SKIP  = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_WAVE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FMT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_PCM   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SIZE_MISM = 3'd5;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [STATUS_W-1:0] status_code;
    logic [HALF_W-1:0]   channel_count;
    logic [WORD_W-1:0]   samples_per_second;
    logic [HALF_W-1:0]   sample_bits;
    logic [WORD_W-1:0]   payload_length;
    logic                final_item;
  } result_t;

endpackage

@@ rtl/core/wcsp_if.sv @@
// Valid/ready channel interfaces for the parser's byte input and result output.
interface wcsp_in_if;
  import wcsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_mark;

  modport source (output valid, data_byte, end_mark, input ready);
  modport sink   (input valid, data_byte, end_mark, output ready);
endinterface

interface wcsp_out_if;
  import wcsp_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [BYTE_W-1:0]   payload_byte;
  logic [STATUS_W-1:0] status_code;
  logic [HALF_W-1:0]   channel_count;
  logic [WORD_W-1:0]   samples_per_second;
  logic [HALF_W-1:0]   sample_bits;
  logic [WORD_W-1:0]   payload_length;
  logic                final_item;

  modport source (output valid, kind, payload_byte, status_code, channel_count,
                  samples_per_second, sample_bits, payload_length, final_item,
                  input ready);
  modport sink   (input valid, kind, payload_byte, status_code, channel_count,
                  samples_per_second, sample_bits, payload_length, final_item,
                  output ready);
endinterface

@@ rtl/core/wave_chunk_stream_parser.sv @@
// WAVE chunk stream parser top level: byte-wise RIFF/WAVE header walk with payload pass-through.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------------
//  stream   | in  | valid / ready | data_byte[7:0], end_mark
//  result   | out | valid / ready | kind, payload_byte, status_code, channel_count,
//           |     |               | samples_per_second, sample_bits, payload_length,
//           |     |               | final_item
//
// One byte per cycle while stream.ready is high: each accepted transaction is parsed in
// the cycle it arrives; its result (if any) goes to the output register or the skid entry.
// Output side is an output register plus one skid entry; stream.ready drops only
// while the skid entry is full (a second result waiting behind a stalled output
// register) and rises again in the cycle after the next result.ready.
// rst (synchronous, active high) returns the parser to the header phase with all
// totals and saved fmt fields cleared and both output entries empty.
// The end mark also returns the parse state to reset for the next stream.
module wave_chunk_stream_parser (
  input  logic              clk,
  input  logic              rst,
  wcsp_in_if.sink           stream,
  wcsp_out_if.source        result
);
  import wcsp_pkg::*;

  // Parse state
  logic [PHASE_W-1:0]  phase,      phase_next;
  logic [WORD_W-1:0]   pos,        pos_next;      // byte index or bytes left
  logic [WORD_W-1:0]   tag,        tag_next;      // tag, form, fmt code + extra size
  logic [WORD_W-1:0]   len,        len_next;
  logic [63:0]         fmt_buf,    fmt_buf_next;  // channels, rate, bits
  logic [WORD_W-1:0]   riff_size,  riff_size_next;
  logic [TOTAL_W-1:0]  fmt_total,  fmt_total_next;
  logic [TOTAL_W-1:0]  data_total, data_total_next;
  logic [TOTAL_W-1:0]  unk_total,  unk_total_next;
  logic [HALF_W-1:0]   saved_ch,   saved_ch_next;
  logic [WORD_W-1:0]   saved_rate, saved_rate_next;
  logic [HALF_W-1:0]   saved_bits, saved_bits_next;
  logic [STATUS_W-1:0] err,        err_next;

  // Output register and skid entry
  logic    out_valid, skid_valid;
  result_t out_r, skid_r;

  logic               accept, pop;
  logic               have_res;
  result_t            res;
  logic               finish;
  logic [STATUS_W-1:0] err_code;
  logic [WORD_W-1:0]  extra_w;
  logic [35:0]        size_sum;
  logic [WORD_W-1:0]  last_len;

  assign stream.ready = !skid_valid;
  assign accept       = stream.valid && stream.ready;
  assign pop          = out_valid && result.ready;

  // Declared length of the last full data chunk
  assign last_len = (data_total != '0) ? (data_total[WORD_W-1:0] - 32'd8) : '0;
  assign size_sum = 36'd4 + {2'b00, fmt_total} + {2'b00, data_total}
                  + {2'b00, unk_total};

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    tag_next        = tag;
    len_next        = len;
    fmt_buf_next    = fmt_buf;
    riff_size_next  = riff_size;
    fmt_total_next  = fmt_total;
    data_total_next = data_total;
    unk_total_next  = unk_total;
    saved_ch_next   = saved_ch;
    saved_rate_next = saved_rate;
    saved_bits_next = saved_bits;
    err_next        = err;
    have_res        = 1'b0;
    res             = '0;
    finish          = 1'b0;
    err_code        = ST_OK;
    extra_w         = '0;

    // status template: current saved fields
    res.kind               = KIND_STATUS;
    res.channel_count      = saved_ch;
    res.samples_per_second = saved_rate;
    res.sample_bits        = saved_bits;
    res.payload_length     = last_len;
    res.final_item         = 1'b1;

    if (accept) begin
      if (stream.end_mark) begin
        if (err == ST_OK) begin
          have_res = 1'b1;
          if (phase == PH_HDR && pos == '0) begin
            res.status_code = (size_sum == {4'd0, riff_size}) ? ST_OK : ST_SIZE_MISM;
          end else begin
            res.status_code = ST_TRUNCATED;
          end
        end
        // end mark always restarts the parser
        phase_next      = PH_HDR;
        pos_next        = '0;
        tag_next        = '0;
        len_next        = '0;
        fmt_buf_next    = '0;
        riff_size_next  = '0;
        fmt_total_next  = '0;
        data_total_next = '0;
        unk_total_next  = '0;
        saved_ch_next   = '0;
        saved_rate_next = '0;
        saved_bits_next = '0;
        err_next        = ST_OK;
      end else if (err == ST_OK) begin
        case (phase)
          PH_FORM: begin
            tag_next[{pos[1:0], 3'b000} +: 8] = stream.data_byte;
            pos_next = pos + 32'd1;
            if (pos >= 32'd3) begin
              if (tag_next != FORM_WAVE) begin
                err_code = ST_NOT_WAVE;
              end else begin
                riff_size_next = len;
                phase_next     = PH_HDR;
                pos_next       = '0;
              end
            end
          end
          PH_FMT: begin
            if (pos < 32'd2) begin
              tag_next[{1'b0, pos[0], 3'b000} +: 8] = stream.data_byte;
            end else if (pos < 32'd8) begin
              fmt_buf_next[{pos[2:0] - 3'd2, 3'b000} +: 8] = stream.data_byte;
            end else if (pos >= 32'd14 && pos < 32'd16) begin
              fmt_buf_next[{2'b11, pos[0], 3'b000} +: 8] = stream.data_byte;
            end
            pos_next = pos + 32'd1;
            if (pos >= 32'd15) begin
              pos_next = '0;
              if (len == 32'd16) begin
                finish = 1'b1;
              end else if (len == 32'd18) begin
                phase_next = PH_EXT;
              end else begin
                err_code = ST_BAD_FMT;
              end
            end
          end
          PH_EXT: begin
            tag_next[{1'b1, pos[0], 3'b000} +: 8] = stream.data_byte;
            extra_w  = {16'd0, tag_next[31:16]};
            pos_next = pos + 32'd1;
            if (pos >= 32'd1) begin
              unk_total_next = unk_total + {2'b00, extra_w};
              if (extra_w == '0) begin
                finish = 1'b1;
              end else begin
                pos_next   = extra_w;
                phase_next = PH_SKIPX;
              end
            end
          end
          PH_SKIPX: begin
            pos_next = pos - 32'd1;
            if (pos_next == '0) begin
              finish = 1'b1;
            end
          end
          PH_DATA: begin
            have_res           = 1'b1;
            res                = '0;
            res.kind           = KIND_PAYLOAD;
            res.payload_byte   = stream.data_byte;
            pos_next = pos - 32'd1;
            if (pos_next == '0) begin
              data_total_next = {2'b00, len} + 34'd8;
              phase_next      = PH_HDR;
            end
          end
          PH_SKIP: begin
            pos_next = pos - 32'd1;
            if (pos_next == '0) begin
              phase_next = PH_HDR;
            end
          end
          default: begin
            // chunk header: 4 tag bytes then 4 length bytes
            if (pos == '0) begin
              tag_next = '0;
              len_next = '0;
            end
            if (pos < 32'd4) begin
              tag_next[{pos[1:0], 3'b000} +: 8] = stream.data_byte;
            end else begin
              len_next[{pos[1:0], 3'b000} +: 8] = stream.data_byte;
            end
            pos_next   = pos + 32'd1;
            phase_next = PH_HDR;
            if (pos >= 32'd7) begin
              pos_next = '0;
              if (tag == TAG_RIFF) begin
                tag_next   = '0;
                phase_next = PH_FORM;
              end else if (tag == TAG_FMT) begin
                tag_next     = '0;
                fmt_buf_next = '0;
                phase_next   = PH_FMT;
              end else if (tag == TAG_DATA) begin
                if (len_next == '0) begin
                  data_total_next = 34'd8;
                end else begin
                  pos_next   = len_next;
                  phase_next = PH_DATA;
                end
              end else begin
                unk_total_next = unk_total + {2'b00, len_next} + 34'd8;
                pos_next       = len_next;
                phase_next     = (len_next == '0) ? PH_HDR : PH_SKIP;
              end
            end
          end
        endcase

        // close of an fmt chunk: PCM check, then keep its fields
        if (finish) begin
          if (tag_next[15:0] != FMT_PCM) begin
            err_code = ST_NOT_PCM;
          end else begin
            saved_ch_next   = fmt_buf_next[15:0];
            saved_rate_next = fmt_buf_next[47:16];
            saved_bits_next = fmt_buf_next[63:48];
            fmt_total_next  = {2'b00, len} + 34'd8;
            phase_next      = PH_HDR;
            pos_next        = '0;
          end
        end

        // first error: report it now, ignore bytes until the end mark
        if (err_code != ST_OK) begin
          err_next        = err_code;
          have_res        = 1'b1;
          res.status_code = err_code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR;
      pos        <= '0;
      tag        <= '0;
      len        <= '0;
      fmt_buf    <= '0;
      riff_size  <= '0;
      fmt_total  <= '0;
      data_total <= '0;
      unk_total  <= '0;
      saved_ch   <= '0;
      saved_rate <= '0;
      saved_bits <= '0;
      err        <= ST_OK;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      tag        <= tag_next;
      len        <= len_next;
      fmt_buf    <= fmt_buf_next;
      riff_size  <= riff_size_next;
      fmt_total  <= fmt_total_next;
      data_total <= data_total_next;
      unk_total  <= unk_total_next;
      saved_ch   <= saved_ch_next;
      saved_rate <= saved_rate_next;
      saved_bits <= saved_bits_next;
      err        <= err_next;
    end
  end

  // Output register with skid entry; new results only arrive while skid is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_r      <= skid_r;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= have_res;
          out_r     <= res;
        end
      end else if (out_valid) begin
        if (have_res) begin
          skid_r     <= res;
          skid_valid <= 1'b1;
        end
      end else begin
        out_valid <= have_res;
        out_r     <= res;
      end
    end
  end

  assign result.valid              = out_valid;
  assign result.kind               = out_r.kind;
  assign result.payload_byte       = out_r.payload_byte;
  assign result.status_code        = out_r.status_code;
  assign result.channel_count      = out_r.channel_count;
  assign result.samples_per_second = out_r.samples_per_second;
  assign result.sample_bits        = out_r.sample_bits;
  assign result.payload_length     = out_r.payload_length;
  assign result.final_item         = out_r.final_item;

endmodule
